// File: hw/rtl/sfcep_pkg.sv
`timescale 1ns / 1ps

package sfcep_pkg;

  localparam int unsigned UsW    = 16;
  localparam int unsigned TpuW   = 4;
  localparam int unsigned TickW  = 19;
  localparam int unsigned ProdW  = UsW + TpuW;
  localparam int unsigned ChanW  = 2;
  localparam int unsigned NumCh  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0] TickMax = '1;

  localparam logic [UsW-1:0]  MinWidthRst   = 16'd1000;
  localparam logic [UsW-1:0]  MaxWidthRst   = 16'd2000;
  localparam logic [TpuW-1:0] TicksPerUsRst = 4'd2;
  localparam logic [TickW-1:0] ChanTicksRst = 19'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_WIDTH  = 2'd0,
    REG_MAX_WIDTH  = 2'd1,
    REG_TICKS_PER  = 2'd2,
    REG_UNUSED     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_SET  = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

endpackage

// File: hw/rtl/sequential_four_channel_esc_pulse.sv
`timescale 1ns / 1ps

// A result is registered at the edge that accepts its request.
// Throughput: one request per cycle; the output register lets a new request
// enter whenever the held result is taken in the same cycle or none is held.
// Reset (synchronous, rst high): channel 0 active, counter at zero, every
// channel width at the minimum, limits 1000/2000 us at 2 ticks per us.
module sequential_four_channel_esc_pulse (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [1:0]  channel,
  input  logic [15:0] width_us,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  pin_levels,
  output logic [1:0]  active_out,
  output logic        over_max
);

  logic [sfcep_pkg::UsW-1:0]   min_width;
  logic [sfcep_pkg::UsW-1:0]   max_width;
  logic [sfcep_pkg::TpuW-1:0]  ticks_per_us;

  logic [sfcep_pkg::TickW-1:0] channel_ticks [sfcep_pkg::NumCh];
  logic [sfcep_pkg::ChanW-1:0] active_channel;
  logic [sfcep_pkg::TickW-1:0] tick_count;

  logic                        in_fire;
  logic                        is_set;
  logic [sfcep_pkg::UsW-1:0]   clamped;
  logic                        over;
  logic [sfcep_pkg::ProdW-1:0] product;
  logic [sfcep_pkg::TickW-1:0] set_ticks;
  logic [sfcep_pkg::TickW-1:0] count_inc;
  logic                        wrap;
  logic [sfcep_pkg::ChanW-1:0] active_channel_next;
  logic [sfcep_pkg::TickW-1:0] tick_count_next;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_set   = (action == sfcep_pkg::ACT_SET);

  // clamp the request to [min, max]; when limits cross, a width below min gets min and any other gets max
  always_comb begin
    over    = 1'b0;
    clamped = width_us;
    if (width_us < min_width) begin
      clamped = min_width;
    end else if (width_us > max_width) begin
      clamped = max_width;
      over    = 1'b1;
    end
  end

  assign product   = sfcep_pkg::ProdW'(clamped) * sfcep_pkg::ProdW'(ticks_per_us);
  // saturate the converted width
  assign set_ticks = (product > sfcep_pkg::ProdW'(sfcep_pkg::TickMax)) ?
                     sfcep_pkg::TickMax : product[sfcep_pkg::TickW-1:0];

  assign count_inc = tick_count + 1'b1;
  assign wrap      = (count_inc >= channel_ticks[active_channel]);

  always_comb begin
    active_channel_next = active_channel;
    tick_count_next     = tick_count;
    if (!is_set) begin
      if (wrap) begin
        active_channel_next = active_channel + 1'b1;
        tick_count_next     = '0;
      end else begin
        tick_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width      <= sfcep_pkg::MinWidthRst;
      max_width      <= sfcep_pkg::MaxWidthRst;
      ticks_per_us   <= sfcep_pkg::TicksPerUsRst;
      for (int i = 0; i < sfcep_pkg::NumCh; i++) begin
        channel_ticks[i] <= sfcep_pkg::ChanTicksRst;
      end
      active_channel <= '0;
      tick_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfcep_pkg::REG_MIN_WIDTH: min_width    <= cfg_data;
          sfcep_pkg::REG_MAX_WIDTH: max_width    <= cfg_data;
          sfcep_pkg::REG_TICKS_PER: ticks_per_us <= cfg_data[sfcep_pkg::TpuW-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (is_set) begin
          channel_ticks[channel] <= set_ticks;
        end
        active_channel <= active_channel_next;
        tick_count     <= tick_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register; hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pin_levels <= 4'(1) << active_channel_next;
      active_out <= active_channel_next;
      over_max   <= is_set && over;
    end
  end

  a_onehot_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pin_levels == (4'(1) << active_out)))
    else $error("pin levels disagree with active channel");

  a_set_holds_channel: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_set) |=> $stable(active_channel) && $stable(tick_count))
    else $error("set request moved the sequencer");

  a_tick_no_over: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_set) |=> !over_max)
    else $error("tick request flagged over_max");

  a_advance_restarts: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && active_channel != $past(active_channel)) |->
      (tick_count == '0 &&
       active_channel == $past(active_channel) + sfcep_pkg::ChanW'(1)))
    else $error("channel advance without counter restart");

endmodule

// File: tb/sv/sequential_four_channel_esc_pulse_test.sv
`timescale 1ns / 1ps

module sequential_four_channel_esc_pulse_test;

  typedef struct packed {
    logic [sfcep_pkg::NumCh-1:0] pins;
    logic [sfcep_pkg::ChanW-1:0] active;
    logic                        over;
  } pulse_state_t;

  class esc_pulse_scoreboard;
    logic [sfcep_pkg::UsW-1:0]   min_us;
    logic [sfcep_pkg::UsW-1:0]   max_us;
    logic [sfcep_pkg::TpuW-1:0]  tpu;
    logic [sfcep_pkg::TickW-1:0] chan_ticks[sfcep_pkg::NumCh];
    logic [sfcep_pkg::ChanW-1:0] active;
    logic [sfcep_pkg::TickW-1:0] count;
    pulse_state_t     states_due[$];
    int               errors;
    int               checked;
    int               switches;

    function logic [sfcep_pkg::TickW-1:0] to_ticks(logic [sfcep_pkg::UsW-1:0] us);
      logic [sfcep_pkg::ProdW-1:0] prod;
      prod = us * tpu;
      // saturate at the counter width
      if (prod[sfcep_pkg::ProdW-1:sfcep_pkg::TickW] != 0) return sfcep_pkg::TickMax;
      return prod[sfcep_pkg::TickW-1:0];
    endfunction

    function void reset_state();
      min_us = sfcep_pkg::MinWidthRst;
      max_us = sfcep_pkg::MaxWidthRst;
      tpu    = sfcep_pkg::TicksPerUsRst;
      for (int i = 0; i < sfcep_pkg::NumCh; i++) chan_ticks[i] = to_ticks(min_us);
      active = '0;
      count  = '0;
    endfunction

    function void write_register(sfcep_pkg::cfg_reg_t idx, logic [sfcep_pkg::UsW-1:0] data);
      case (idx)
        sfcep_pkg::REG_MIN_WIDTH: min_us = data;
        sfcep_pkg::REG_MAX_WIDTH: max_us = data;
        sfcep_pkg::REG_TICKS_PER: tpu = data[sfcep_pkg::TpuW-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(sfcep_pkg::action_t act, logic [sfcep_pkg::ChanW-1:0] ch,
                               logic [sfcep_pkg::UsW-1:0] w);
      pulse_state_t st;
      logic [sfcep_pkg::UsW-1:0] clamped;
      st.over = 1'b0;
      if (act == sfcep_pkg::ACT_SET) begin
        // check the minimum first; with crossed limits a width below it gives the minimum, any other the maximum
        if (w < min_us) begin
          clamped = min_us;
        end else if (w > max_us) begin
          clamped = max_us;
          st.over = 1'b1;
        end else begin
          clamped = w;
        end
        chan_ticks[ch] = to_ticks(clamped);
      end else begin
        count = count + 1'b1;
        if (count >= chan_ticks[active]) begin
          active = active + 1'b1;
          count = '0;
          switches++;
        end
      end
      st.pins   = sfcep_pkg::NumCh'(1) << active;
      st.active = active;
      states_due.push_back(st);
    endfunction

    function void check_result(logic [sfcep_pkg::NumCh-1:0] pins,
                               logic [sfcep_pkg::ChanW-1:0] act_ch, logic over);
      pulse_state_t exp_st;
      if (states_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result pin_levels %h active_out %0d over_max %0b",
                 $time, pins, act_ch, over);
        return;
      end
      exp_st = states_due.pop_front();
      checked++;
      if (pins !== exp_st.pins) begin
        errors++;
        $display("%0t: pin_levels expected %h actual %h", $time, exp_st.pins, pins);
      end
      if (act_ch !== exp_st.active) begin
        errors++;
        $display("%0t: active_out expected %0d actual %0d", $time, exp_st.active, act_ch);
      end
      if (over !== exp_st.over) begin
        errors++;
        $display("%0t: over_max expected %0b actual %0b", $time, exp_st.over, over);
      end
    endfunction

    function int pending();
      return states_due.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [15:0]      cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic             action;
  logic [1:0]       channel;
  logic [15:0]      width_us;
  logic             out_valid;
  logic             out_ready;
  logic [3:0]       pin_levels;
  logic [1:0]       active_out;
  logic             over_max;

  esc_pulse_scoreboard sb;
  int send_idle;
  int recv_idle;
  int hold_left;
  int sent;
  int settings_run;

  sequential_four_channel_esc_pulse dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .channel    (channel),
    .width_us   (width_us),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pin_levels (pin_levels),
    .active_out (active_out),
    .over_max   (over_max)
  );

  always #1 clk = ~clk;

  // result side: check what was taken, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(pin_levels, active_out, over_max);
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic send_request(sfcep_pkg::action_t act, logic [1:0] ch, logic [15:0] w);
    in_valid <= 1'b1;
    action   <= act;
    channel  <= ch;
    width_us <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(act, ch, w);
    sent++;
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
  endtask

  task automatic send_tick();
    send_request(sfcep_pkg::ACT_TICK, 2'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] pick_width(int lo, int hi);
    int a;
    int b;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      3, 4, 5: begin a = lo - 2; b = lo + 3; end
      6, 7: begin a = hi - 3; b = hi + 2; end
      default: begin a = 0; b = 8; end
    endcase
    if (a < 0) a = 0;
    if (b > 65535) b = 65535;
    return 16'($urandom_range(b, a));
  endfunction

  // drop valid and wait until every result has been taken
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_limits(logic [15:0] lo, logic [15:0] hi, logic [3:0] tpu);
    logic [15:0] vals[4];
    vals[0] = lo;
    vals[1] = hi;
    vals[2] = (16'($urandom) & 16'hFFF0) | 16'(tpu);
    vals[3] = 16'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_register(sfcep_pkg::cfg_reg_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  localparam int PhaseMin[7] = '{0, 0, 10, 65535, 1, 0, 3};
  localparam int PhaseMax[7] = '{65535, 0, 3, 65535, 6, 4, 9};
  localparam int PhaseTpu[7] = '{15, 0, 2, 8, 1, 3, 2};

  initial begin
    int lo;
    int hi;
    int tpu;
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    action    = 1'b0;
    channel   = '0;
    width_us  = '0;
    out_ready = 1'b0;
    send_idle = 25;
    recv_idle = 78;
    hold_left = 0;
    sent      = 0;
    settings_run = 1;
    sb = new;
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset limits: clamp below, above, and at both edges
    send_tick();
    send_request(sfcep_pkg::ACT_SET, 2'd1, 16'd0);
    send_request(sfcep_pkg::ACT_SET, 2'd2, 16'hFFFF);
    send_request(sfcep_pkg::ACT_SET, 2'd3, 16'd2001);
    send_request(sfcep_pkg::ACT_SET, 2'd0, 16'd1000);
    send_request(sfcep_pkg::ACT_SET, 2'd1, 16'd2000);
    send_request(sfcep_pkg::ACT_SET, 2'd3, 16'd999);

    drain_requests();
    program_limits(16'd2, 16'd5, 4'd1);
    send_request(sfcep_pkg::ACT_SET, 2'd0, 16'd0);
    send_request(sfcep_pkg::ACT_SET, 2'd1, 16'd9);
    send_request(sfcep_pkg::ACT_SET, 2'd2, 16'd5);
    send_request(sfcep_pkg::ACT_SET, 2'd3, 16'd3);
    repeat (5) send_tick();
    // lower the running channel below its counter
    send_request(sfcep_pkg::ACT_SET, 2'd1, 16'd0);
    repeat (8) send_tick();

    for (int p = 0; p < 8; p++) begin
      drain_requests();
      if (p < 3) begin
        send_idle = 25;
        recv_idle = 78;
      end else if (p < 6) begin
        send_idle = 78;
        recv_idle = 25;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 7) begin
        lo  = $urandom_range(0, 20);
        hi  = $urandom_range(0, 20);
        tpu = $urandom_range(0, 15);
      end else begin
        lo  = PhaseMin[p];
        hi  = PhaseMax[p];
        tpu = PhaseTpu[p];
      end
      program_limits(16'(lo), 16'(hi), 4'(tpu));
      // hold the result side off so the block backs up into the request side
      if (p == 6) hold_left = 300;
      for (int n = 0; n < 250; n++) begin
        if (p == 4 && n == 125) drain_requests();
        if ($urandom_range(0, 3) != 0) send_tick();
        else send_request(sfcep_pkg::ACT_SET, 2'($urandom), pick_width(lo, hi));
      end
    end
    drain_requests();

    $display("sent %0d requests under %0d limit settings, checked %0d results",
             sent, settings_run, sb.checked);
    $display("saw %0d channel handovers, %0d mismatches", sb.switches, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sequential_four_channel_esc_pulse_test passed");
    end else begin
      $display("sequential_four_channel_esc_pulse_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("sequential_four_channel_esc_pulse_test failed");
    $finish;
  end

endmodule
